// ----- src/msp_pkg.sv -----
// ----------------------------------------------------------------------------
// Saddle point finder package
// Shared widths, register indexes, reset values and the size clamp.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 8;

  localparam int VALUE_W     = 8;
  localparam int POS_W       = 4;
  localparam int TOTAL_W     = 7;
  localparam int SIZE_W      = 7;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 16;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 7'd127;
  localparam logic [TOTAL_W-1:0] RESULT_CAP = 7'd64;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

  // A size of zero counts as one; sizes beyond the array saturate.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input int top);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (int'(v) > top) begin
      res = SIZE_W'(top);
    end else begin
      res = SIZE_W'(v);
    end
    return res;
  endfunction

endpackage

// ----- src/msp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module msp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/msp_load.sv -----
// ----------------------------------------------------------------------------
// Saddle point finder load path
// Stores incoming elements, tracks the running row maximum and updates the
// column minima by read-modify-write with forwarding.
// ----------------------------------------------------------------------------
module msp_load #(
  parameter int MAX_ROWS = msp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = msp_pkg::MAX_COLS_DEF,
  localparam int DEPTH = MAX_ROWS * MAX_COLS,
  localparam int EAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RCW   = $clog2(MAX_ROWS + 1),
  localparam int CCW   = $clog2(MAX_COLS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [msp_pkg::CFG_W-1:0]    cfg_rows,
  input  logic [msp_pkg::CFG_W-1:0]    cfg_cols,
  input  logic                         load_en,
  input  logic                         in_tvalid,
  input  logic [msp_pkg::VALUE_W-1:0]  in_value,
  output logic                         in_tready,
  output logic                         elem_we,
  output logic [EAW-1:0]               elem_waddr,
  output logic [msp_pkg::VALUE_W-1:0]  elem_wdata,
  output logic                         rmax_we,
  output logic [RW-1:0]                rmax_waddr,
  output logic [msp_pkg::VALUE_W-1:0]  rmax_wdata,
  output logic                         cmin_we,
  output logic [CW-1:0]                cmin_waddr,
  output logic [msp_pkg::VALUE_W-1:0]  cmin_wdata,
  output logic                         cmin_re,
  output logic [CW-1:0]                cmin_raddr,
  input  logic [msp_pkg::VALUE_W-1:0]  cmin_rdata,
  output logic                         done,
  output logic [RCW-1:0]               rows,
  output logic [CCW-1:0]               cols
);

  localparam int VW = msp_pkg::VALUE_W;

  logic           acc;
  logic           first;
  logic [RCW-1:0] rows_eff;
  logic [CCW-1:0] cols_eff;
  logic           col_end;
  logic           row_last;
  logic [VW-1:0]  rmax_new;

  logic [RW-1:0]  r;
  logic [CW-1:0]  c;
  logic [EAW-1:0] base;
  logic [VW-1:0]  rmax;

  logic           s1_valid;
  logic [CW-1:0]  s1_col;
  logic [VW-1:0]  s1_val;
  logic           s1_first_row;
  logic [VW-1:0]  cmin_old;
  logic [VW-1:0]  cmin_new;

  logic           fw_valid;
  logic [CW-1:0]  fw_col;
  logic [VW-1:0]  fw_data;

  assign in_tready = load_en;
  assign acc       = in_tvalid && load_en;
  assign first     = (r == '0) && (c == '0);
  assign rows_eff  = first ? RCW'(msp_pkg::clamp_size(cfg_rows, MAX_ROWS)) : rows;
  assign cols_eff  = first ? CCW'(msp_pkg::clamp_size(cfg_cols, MAX_COLS)) : cols;
  assign col_end   = (CCW'(c) + CCW'(1)) == cols_eff;
  assign row_last  = (RCW'(r) + RCW'(1)) == rows_eff;
  assign rmax_new  = ((c == '0) || (in_value > rmax)) ? in_value : rmax;
  assign done      = acc && col_end && row_last;

  assign elem_we    = acc;
  assign elem_waddr = base + EAW'(c);
  assign elem_wdata = in_value;
  assign rmax_we    = acc && col_end;
  assign rmax_waddr = r;
  assign rmax_wdata = rmax_new;
  assign cmin_re    = acc;
  assign cmin_raddr = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      r        <= '0;
      c        <= '0;
      base     <= '0;
      rows     <= RCW'(msp_pkg::clamp_size(msp_pkg::CFG_RESET, MAX_ROWS));
      cols     <= CCW'(msp_pkg::clamp_size(msp_pkg::CFG_RESET, MAX_COLS));
      s1_valid <= 1'b0;
      fw_valid <= 1'b0;
    end else begin
      s1_valid <= acc;
      fw_valid <= s1_valid;
      if (acc) begin
        if (first) begin
          rows <= rows_eff;
          cols <= cols_eff;
        end
        if (col_end) begin
          c <= '0;
          if (row_last) begin
            r    <= '0;
            base <= '0;
          end else begin
            r    <= r + 1'b1;
            base <= base + EAW'(MAX_COLS);
          end
        end else begin
          c <= c + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rmax         <= rmax_new;
      s1_col       <= c;
      s1_val       <= in_value;
      s1_first_row <= (r == '0);
    end
    fw_col  <= s1_col;
    fw_data <= cmin_new;
  end

  // The RAM reads before it writes, so a write made while the read was in flight is forwarded.
  assign cmin_old   = (fw_valid && (fw_col == s1_col)) ? fw_data : cmin_rdata;
  assign cmin_new   = (s1_first_row || (s1_val < cmin_old)) ? s1_val : cmin_old;
  assign cmin_we    = s1_valid;
  assign cmin_waddr = s1_col;
  assign cmin_wdata = cmin_new;

endmodule

// ----- src/msp_scan.sv -----
// ----------------------------------------------------------------------------
// Saddle point finder scan sequencer
// Counts the saddle points in a first pass, then emits them in a second pass
// through a registered output stage; with none, it emits one not-found item.
// ----------------------------------------------------------------------------
module msp_scan #(
  parameter int MAX_ROWS = msp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = msp_pkg::MAX_COLS_DEF,
  localparam int DEPTH = MAX_ROWS * MAX_COLS,
  localparam int EAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RCW   = $clog2(MAX_ROWS + 1),
  localparam int CCW   = $clog2(MAX_COLS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         done,
  input  logic [RCW-1:0]               rows,
  input  logic [CCW-1:0]               cols,
  output logic                         load_en,
  output logic                         rd_en,
  output logic [EAW-1:0]               elem_raddr,
  output logic [RW-1:0]                rmax_raddr,
  output logic [CW-1:0]                cmin_raddr,
  input  logic [msp_pkg::VALUE_W-1:0]  elem_rdata,
  input  logic [msp_pkg::VALUE_W-1:0]  rmax_rdata,
  input  logic [msp_pkg::VALUE_W-1:0]  cmin_rdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [msp_pkg::POS_W-1:0]    out_row,
  output logic [msp_pkg::POS_W-1:0]    out_column,
  output logic                         out_found,
  output logic [msp_pkg::TOTAL_W-1:0]  out_total,
  output logic                         out_last
);

  localparam int POS_W = msp_pkg::POS_W;
  localparam int TW    = msp_pkg::TOTAL_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DRAIN = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_NONE  = 5'b10000
  } state_t;

  state_t         state;
  state_t         state_next;
  logic           emit_pass;
  logic [RW-1:0]  i;
  logic [CW-1:0]  j;
  logic [EAW-1:0] base;
  logic [TW-1:0]  total;
  logic [TW-1:0]  total_next;
  logic [TW-1:0]  n;
  logic [TW-1:0]  emitted;

  logic           match;
  logic           col_end;
  logic           at_end;
  logic           out_free;
  logic           emit_last;
  logic           load_hit;
  logic           load_none;
  logic           step;
  logic           rewind;

  assign load_en    = (state == S_IDLE);
  assign rd_en      = (state == S_READ);
  assign elem_raddr = base + EAW'(j);
  assign rmax_raddr = i;
  assign cmin_raddr = j;

  assign match     = (elem_rdata == rmax_rdata) && (elem_rdata == cmin_rdata);
  assign col_end   = (CCW'(j) + CCW'(1)) == cols;
  assign at_end    = col_end && ((RCW'(i) + RCW'(1)) == rows);
  assign out_free  = !out_valid || out_ready;
  assign emitted   = (total < msp_pkg::RESULT_CAP) ? total : msp_pkg::RESULT_CAP;
  assign emit_last = (n + TW'(1)) == emitted;
  assign total_next = (match && (total != msp_pkg::TOTAL_MAX)) ? total + TW'(1) : total;

  always_comb begin
    state_next = state;
    load_hit   = 1'b0;
    load_none  = 1'b0;
    step       = 1'b0;
    rewind     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (done) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (!emit_pass) begin
          if (at_end) begin
            rewind     = 1'b1;
            state_next = (total_next == '0) ? S_NONE : S_READ;
          end else begin
            step       = 1'b1;
            state_next = S_READ;
          end
        end else if (match) begin
          if (out_free) begin
            load_hit = 1'b1;
            if (emit_last || at_end) begin
              state_next = S_IDLE;
            end else begin
              step       = 1'b1;
              state_next = S_READ;
            end
          end
        end else if (at_end) begin
          state_next = S_IDLE;
        end else begin
          step       = 1'b1;
          state_next = S_READ;
        end
      end
      S_NONE: begin
        if (out_free) begin
          load_none  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      emit_pass <= 1'b0;
      i         <= '0;
      j         <= '0;
      base      <= '0;
      total     <= '0;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        emit_pass <= 1'b0;
        i         <= '0;
        j         <= '0;
        base      <= '0;
        total     <= '0;
        n         <= '0;
      end
      if ((state == S_EVAL) && !emit_pass) begin
        total <= total_next;
      end
      if (rewind) begin
        emit_pass <= 1'b1;
        i         <= '0;
        j         <= '0;
        base      <= '0;
      end
      if (step) begin
        if (col_end) begin
          j    <= '0;
          i    <= i + 1'b1;
          base <= base + EAW'(MAX_COLS);
        end else begin
          j <= j + 1'b1;
        end
      end
      if (load_hit) begin
        n <= n + TW'(1);
      end
      if (load_hit || load_none) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_hit) begin
      out_row    <= POS_W'({1'b0, i} + 1'b1);
      out_column <= POS_W'({1'b0, j} + 1'b1);
      out_found  <= 1'b1;
      out_total  <= total;
      out_last   <= emit_last;
    end else if (load_none) begin
      out_row    <= '0;
      out_column <= '0;
      out_found  <= 1'b0;
      out_total  <= '0;
      out_last   <= 1'b1;
    end
  end

endmodule

// ----- src/matrix_saddle_point_finder.sv -----
// ----------------------------------------------------------------------------
// Matrix saddle point finder
// Loads an unsigned byte matrix in row-major order and reports every element
// that is both the maximum of its row and the minimum of its column.
//
//   Channel  Direction  Handshake                 Payload
//   s_axis   in         s_axis_tvalid/tready      tdata: value
//   m_axis   out        m_axis_tvalid/tready      tdata: row, column, total;
//                                                 tuser: found; tlast: last
//   cfg      in         cfg_we                    cfg_index, cfg_data
//
// Loading takes one item per cycle. After the last element the block passes
// through a drain state, counts over the matrix, then scans it again to emit
// any saddle points, reading and then evaluating each position; output stalls
// hold the emit pass. No item is taken during the scan. Reset is synchronous;
// the element store and the row and column extremes need no clearing.
// ----------------------------------------------------------------------------
module matrix_saddle_point_finder #(
  parameter int MAX_ROWS = msp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = msp_pkg::MAX_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msp_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // value[7:0]
  input  logic [msp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // row[3:0], column[7:4], total[14:8], zero[15]
  output logic [msp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // found[0]
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int EAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int VW    = msp_pkg::VALUE_W;

  logic [msp_pkg::CFG_W-1:0]   rows_in_use;
  logic [msp_pkg::CFG_W-1:0]   cols_in_use;

  logic                        load_en;
  logic                        done;
  logic [RCW-1:0]              rows;
  logic [CCW-1:0]              cols;

  logic                        elem_we;
  logic [EAW-1:0]              elem_waddr;
  logic [VW-1:0]               elem_wdata;
  logic [EAW-1:0]              elem_raddr;
  logic [VW-1:0]               elem_rdata;
  logic                        rmax_we;
  logic [RW-1:0]               rmax_waddr;
  logic [VW-1:0]               rmax_wdata;
  logic [RW-1:0]               rmax_raddr;
  logic [VW-1:0]               rmax_rdata;
  logic                        cmin_we;
  logic [CW-1:0]               cmin_waddr;
  logic [VW-1:0]               cmin_wdata;
  logic                        ld_cmin_re;
  logic [CW-1:0]               ld_cmin_raddr;
  logic [CW-1:0]               sc_cmin_raddr;
  logic [VW-1:0]               cmin_rdata;
  logic                        scan_rd;

  logic [msp_pkg::POS_W-1:0]   out_row;
  logic [msp_pkg::POS_W-1:0]   out_column;
  logic [msp_pkg::TOTAL_W-1:0] out_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= msp_pkg::CFG_RESET;
      cols_in_use <= msp_pkg::CFG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == msp_pkg::REG_ROWS_IN_USE) begin
        rows_in_use <= cfg_data;
      end else if (cfg_index == msp_pkg::REG_COLS_IN_USE) begin
        cols_in_use <= cfg_data;
      end
    end
  end

  msp_load #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_load (
    .clk        (clk),
    .rst        (rst),
    .cfg_rows   (rows_in_use),
    .cfg_cols   (cols_in_use),
    .load_en    (load_en),
    .in_tvalid  (s_axis_tvalid),
    .in_value   (s_axis_tdata[VW-1:0]),
    .in_tready  (s_axis_tready),
    .elem_we    (elem_we),
    .elem_waddr (elem_waddr),
    .elem_wdata (elem_wdata),
    .rmax_we    (rmax_we),
    .rmax_waddr (rmax_waddr),
    .rmax_wdata (rmax_wdata),
    .cmin_we    (cmin_we),
    .cmin_waddr (cmin_waddr),
    .cmin_wdata (cmin_wdata),
    .cmin_re    (ld_cmin_re),
    .cmin_raddr (ld_cmin_raddr),
    .cmin_rdata (cmin_rdata),
    .done       (done),
    .rows       (rows),
    .cols       (cols)
  );

  msp_scan #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .done       (done),
    .rows       (rows),
    .cols       (cols),
    .load_en    (load_en),
    .rd_en      (scan_rd),
    .elem_raddr (elem_raddr),
    .rmax_raddr (rmax_raddr),
    .cmin_raddr (sc_cmin_raddr),
    .elem_rdata (elem_rdata),
    .rmax_rdata (rmax_rdata),
    .cmin_rdata (cmin_rdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_row    (out_row),
    .out_column (out_column),
    .out_found  (m_axis_tuser),
    .out_total  (out_total),
    .out_last   (m_axis_tlast)
  );

  msp_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (elem_wdata),
    .re    (scan_rd),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  msp_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_ROWS)
  ) u_rmax_ram (
    .clk   (clk),
    .we    (rmax_we),
    .waddr (rmax_waddr),
    .wdata (rmax_wdata),
    .re    (scan_rd),
    .raddr (rmax_raddr),
    .rdata (rmax_rdata)
  );

  msp_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_COLS)
  ) u_cmin_ram (
    .clk   (clk),
    .we    (cmin_we),
    .waddr (cmin_waddr),
    .wdata (cmin_wdata),
    .re    (ld_cmin_re || scan_rd),
    .raddr (load_en ? ld_cmin_raddr : sc_cmin_raddr),
    .rdata (cmin_rdata)
  );

  assign m_axis_tdata = {1'b0, out_total, out_column, out_row};

endmodule

// ----- dv/matrix_saddle_point_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Saddle point checker
// Watches the register port and both streams of the saddle point finder. It
// keeps its own copy of the matrix, the row maxima and the column minima,
// works out the saddle points of each finished matrix, and compares every
// result item field by field with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module matrix_saddle_point_checker
  import msp_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tuser,
  input  logic                  m_axis_tlast,
  input  logic                  wrap_up,
  output int                    pending,
  output int                    fails
);

  typedef struct packed {
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   column;
    logic               found;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } saddle_t;

  logic [VALUE_W-1:0] grid [MAX_ROWS*MAX_COLS];
  logic [VALUE_W-1:0] row_peak [MAX_ROWS];
  logic [VALUE_W-1:0] col_floor [MAX_COLS];
  logic [CFG_W-1:0]   rows_setting;
  logic [CFG_W-1:0]   cols_setting;
  int                 rows_now;
  int                 cols_now;
  int                 fill_idx;
  bit                 wrapped;
  saddle_t            pending_saddles [$];

  task automatic log_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      log_error($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic int fit_size(input logic [CFG_W-1:0] v, input int top);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > top) begin
      return top;
    end
    return int'(v);
  endfunction

  function automatic bit is_saddle(input int i, input int j);
    logic [VALUE_W-1:0] e;
    e = grid[i*cols_now + j];
    return (e == row_peak[i]) && (e == col_floor[j]);
  endfunction

  task automatic take_element(input logic [VALUE_W-1:0] v);
    int      r;
    int      c;
    int      hits;
    int      limit;
    int      n;
    saddle_t res;
    if (fill_idx == 0) begin
      rows_now = fit_size(rows_setting, MAX_ROWS);
      cols_now = fit_size(cols_setting, MAX_COLS);
    end
    r = fill_idx / cols_now;
    c = fill_idx % cols_now;
    grid[fill_idx] = v;
    if (c == 0 || v > row_peak[r]) begin
      row_peak[r] = v;
    end
    if (r == 0 || v < col_floor[c]) begin
      col_floor[c] = v;
    end
    fill_idx++;
    if (fill_idx < rows_now * cols_now) begin
      return;
    end
    fill_idx = 0;
    hits = 0;
    for (int i = 0; i < rows_now; i++) begin
      for (int j = 0; j < cols_now; j++) begin
        if (is_saddle(i, j) && hits < int'(TOTAL_MAX)) begin
          hits++;
        end
      end
    end
    res = '0;
    if (hits == 0) begin
      res.last = 1'b1;
      pending_saddles.push_back(res);
      return;
    end
    limit = (hits < int'(RESULT_CAP)) ? hits : int'(RESULT_CAP);
    n = 0;
    for (int i = 0; i < rows_now; i++) begin
      for (int j = 0; j < cols_now; j++) begin
        if (n < limit && is_saddle(i, j)) begin
          res.row    = POS_W'(i + 1);
          res.column = POS_W'(j + 1);
          res.found  = 1'b1;
          res.total  = TOTAL_W'(hits);
          res.last   = (n + 1 == limit);
          pending_saddles.push_back(res);
          n++;
        end
      end
    end
  endtask

  task automatic compare_result();
    saddle_t want;
    if (pending_saddles.size() == 0) begin
      log_error($sformatf("result item with nothing outstanding: tdata=%h tuser=%b tlast=%b",
                          m_axis_tdata, m_axis_tuser, m_axis_tlast));
    end else begin
      want = pending_saddles.pop_front();
      check_field("row", int'(m_axis_tdata[3:0]), int'(want.row));
      check_field("column", int'(m_axis_tdata[7:4]), int'(want.column));
      check_field("total", int'(m_axis_tdata[14:8]), int'(want.total));
      check_field("pad bit", int'(m_axis_tdata[15]), 0);
      check_field("found", int'(m_axis_tuser), int'(want.found));
      check_field("last", int'(m_axis_tlast), int'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_setting = CFG_RESET;
      cols_setting = CFG_RESET;
      rows_now     = MAX_ROWS;
      cols_now     = MAX_COLS;
      fill_idx     = 0;
      wrapped      = 1'b0;
      fails        = 0;
      pending_saddles.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        compare_result();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        take_element(s_axis_tdata[VALUE_W-1:0]);
      end
      if (cfg_we) begin
        if (cfg_index == REG_ROWS_IN_USE) begin
          rows_setting = cfg_data;
        end else if (cfg_index == REG_COLS_IN_USE) begin
          cols_setting = cfg_data;
        end
      end
      if (wrap_up && !wrapped) begin
        wrapped = 1'b1;
        if (pending_saddles.size() != 0) begin
          log_error($sformatf("%0d result items never arrived", pending_saddles.size()));
        end
      end
    end
    pending = pending_saddles.size();
  end

endmodule

// ----- dv/tb_matrix_saddle_point_finder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Saddle point finder testbench
// Streams matrices of many sizes and shapes into the finder: a few small
// hand-made cases first, then random, narrow-range, flat and planted-saddle
// matrices, with the sender and the receiver idling at random rates. A
// checker module beside the block predicts and compares the result items.
// ----------------------------------------------------------------------------
module tb_matrix_saddle_point_finder;
  import msp_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int ITEM_TARGET   = 380;

  typedef enum int {FILL_RANDOM, FILL_NARROW, FILL_FLAT, FILL_PLANTED} fill_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ROWS_IN_USE;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  wrap_up = 1'b0;
  int                    pending;
  int                    fails;
  int                    sender_idle_pct = 0;
  int                    sink_stall_pct = 0;
  int                    rows_eff = MAX_ROWS_DEF;
  int                    cols_eff = MAX_COLS_DEF;
  int                    values_sent = 0;
  int                    quiet_cycles = 0;

  matrix_saddle_point_finder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  matrix_saddle_point_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .wrap_up       (wrap_up),
    .pending       (pending),
    .fails         (fails)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the item
  // is taken, with tvalid still high.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    values_sent++;
  endtask

  task automatic set_size(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS_IN_USE;
    cfg_data  <= r;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COLS_IN_USE;
    cfg_data  <= c;
    @(negedge clk);
    cfg_we    <= 1'b0;
    rows_eff = (r == '0) ? 1 : ((int'(r) > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(r));
    cols_eff = (c == '0) ? 1 : ((int'(c) > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(c));
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      return '0;
    end else if (k == 1) begin
      return CFG_W'($urandom_range(9, 15));
    end else if (k == 2) begin
      return CFG_W'(8);
    end
    return CFG_W'($urandom_range(1, 8));
  endfunction

  // A planted matrix puts a value at one spot, at most that value across
  // its row and at least that value down its column.
  task automatic send_matrix(input fill_t how);
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] pivot;
    logic [VALUE_W-1:0] v;
    int                 pr;
    int                 pc;
    int                 r;
    int                 c;
    case ($urandom_range(0, 3))
      0:       base = 8'd0;
      1:       base = 8'd254;
      default: base = VALUE_W'($urandom_range(0, 254));
    endcase
    pivot = VALUE_W'($urandom_range(1, 254));
    pr = $urandom_range(0, rows_eff - 1);
    pc = $urandom_range(0, cols_eff - 1);
    for (int k = 0; k < rows_eff * cols_eff; k++) begin
      r = k / cols_eff;
      c = k % cols_eff;
      case (how)
        FILL_NARROW: v = base + VALUE_W'($urandom_range(0, 1));
        FILL_FLAT:   v = (how == FILL_FLAT && base == 8'd254) ? 8'd255 : base;
        FILL_PLANTED: begin
          if (r == pr && c == pc) begin
            v = pivot;
          end else if (r == pr) begin
            v = VALUE_W'($urandom_range(0, pivot));
          end else if (c == pc) begin
            v = VALUE_W'($urandom_range(pivot, 255));
          end else begin
            v = VALUE_W'($urandom_range(0, 255));
          end
        end
        default:     v = VALUE_W'($urandom_range(0, 255));
      endcase
      send_value(v);
    end
  endtask

  initial begin
    int    phase;
    fill_t how;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_size(4'd1, 4'd1);
    send_value(8'd0);
    send_value(8'd255);
    set_size(4'd0, 4'd0);
    send_value(8'd128);
    set_size(4'd2, 4'd2);
    send_value(8'd1);
    send_value(8'd2);
    send_value(8'd2);
    send_value(8'd1);
    set_size(4'd1, 4'd15);
    send_value(8'd5);
    send_value(8'd255);
    send_value(8'd0);
    send_value(8'd255);
    send_value(8'd7);
    send_value(8'd1);
    send_value(8'd255);
    send_value(8'd3);
    set_size(4'd15, 4'd1);
    send_value(8'd9);
    send_value(8'd3);
    send_value(8'd3);
    send_value(8'd200);
    send_value(8'd255);
    send_value(8'd0);
    send_value(8'd0);
    send_value(8'd17);

    phase = 0;
    while (values_sent < ITEM_TARGET) begin
      if (phase == 0) begin
        set_size(4'd8, 4'd8);
      end else begin
        set_size(pick_size(), pick_size());
      end
      case (phase % 4)
        0: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 65;
          sink_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 65;
        end
        default: begin
          sender_idle_pct = 34;
          sink_stall_pct  = 34;
        end
      endcase
      repeat ($urandom_range(1, 3)) begin
        how = (phase == 0) ? FILL_FLAT : fill_t'($urandom_range(0, 3));
        send_matrix(how);
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    wrap_up <= 1'b1;
    @(negedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
